@@ sv/mms_pkg.sv @@
// Shared types and constants of the mean/median slew filter.
// No dependencies; every other file of the block but mms_div imports this package.
package mms_pkg;

  // Width of the sample and value fields and of the configuration data.
  localparam int unsigned DATA_W = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] CENTER_RESET = 12'd2048;
  localparam logic [DATA_W-1:0] STEP_RESET   = 12'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_CENTER = 2'd1,
    CFG_STEP   = 2'd2
  } mms_cfg_e;

  // Operation applied to the whole row of sort cells at once.
  typedef struct packed {
    logic del;
    logic ins;
    logic rot;
  } mms_cell_ctl_t;

endpackage

@@ sv/mms_if.sv @@
// Valid/ready channel interfaces for the sample input and the value output.
// Depends on mms_pkg for the field width.
interface mms_sample_if import mms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mms_value_if import mms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ sv/mean_median_slew_filter.sv @@
// Mean/median slew filter for slow ADC samples. With filtering on, an accepted sample
// goes through these steps before the next sample can be taken: the transfer, the
// removal of the oldest sample from a sorted row of cells once the window is full,
// and the insertion of the new sample. Next, a run in which the row rotates once
// past its head to pick out the median while a one-bit-a-cycle divider forms the mean;
// the slower of the two sets the length of the run. Last, the target, the slew step
// and the load of the output register. The result is valid once it sits in the output
// register. One sample is in work at a time; the next is taken once the result sits in
// the output register, so a stalled output adds its stall to the item. With filtering
// off, the masked sample comes back and no state changes. Reset starts an empty window
// and a filtered value at code 2048.
module mean_median_slew_filter import mms_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mms_sample_if.sink           in_i,
  mms_value_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned WD      = WINDOW_DEPTH;
  localparam int unsigned CW      = $clog2(WD + 1);
  localparam int unsigned SW      = SB + CW;
  localparam int unsigned FW      = (SB > DATA_W) ? SB : DATA_W;
  localparam int unsigned RUN_LEN = (WD > SB) ? WD : SB;
  localparam int unsigned KW      = $clog2(RUN_LEN + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DEL, S_INS, S_RUN, S_TGT, S_SLEW, S_DONE
  } state_e;

  state_e            state_q;
  logic              enable_q;
  logic [DATA_W-1:0] center_q;
  logic [DATA_W-1:0] step_q;

  logic [CW-1:0]     fill_q;
  logic [SW-1:0]     sum_q;
  logic [KW-1:0]     k_q;
  logic [FW-1:0]     filtered_q, filt_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_val_q;
  logic [DATA_W-1:0] res_q;
  logic [SB-1:0]     x_q, lo_q, hi_q, target_q, target_d;
  logic [SB-1:0]     line_q [WD];

  logic [SB-1:0]     raw;
  logic              in_xfer;
  logic              full;
  logic [SB-1:0]     oldest;
  logic [CW-1:0]     lo_idx, hi_idx;
  logic [SB:0]       med_sum, tgt_sum;
  logic [SB-1:0]     mean;
  logic              div_start;
  mms_cell_ctl_t     ctl;

  logic [SB-1:0]     cell_val [WD];
  logic              cell_vld [WD];
  logic              cell_lt  [WD];
  logic              cell_gt  [WD];

  assign raw     = SB'(in_i.sample);
  assign in_xfer = in_i.valid && in_i.ready;
  assign full    = fill_q == CW'(WD);
  assign oldest  = line_q[WD-1];
  assign lo_idx  = (fill_q - 1'b1) >> 1;
  assign hi_idx  = fill_q >> 1;

  assign in_i.ready  = state_q == S_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.value = out_val_q;

  assign ctl = '{
    del: (state_q == S_DEL) && full,
    ins: state_q == S_INS,
    rot: (state_q == S_RUN) && (k_q < KW'(WD))
  };
  assign div_start = state_q == S_INS;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      center_q <= CENTER_RESET;
      step_q   <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (mms_cfg_e'(cfg_idx_i))
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_CENTER: center_q <= cfg_data_i;
        CFG_STEP:   step_q   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Sorted row of cells: cell 0 holds the smallest filled sample.
  for (genvar i = 0; i < WD; i++) begin : g_cell
    logic [SB-1:0] l_val, r_val;
    logic          l_vld, l_lt, r_vld, r_gt;

    if (i == 0) begin : g_head
      assign l_val = '0;
      assign l_vld = 1'b0;
      assign l_lt  = 1'b0;
    end else begin : g_body
      assign l_val = cell_val[i-1];
      assign l_vld = cell_vld[i-1];
      assign l_lt  = cell_lt[i-1];
    end

    if (i == WD - 1) begin : g_tail
      // The tail takes the head while rotating and an empty slot on removal.
      assign r_val = cell_val[0];
      assign r_vld = ctl.rot && cell_vld[0];
      assign r_gt  = 1'b1;
    end else begin : g_mid
      assign r_val = cell_val[i+1];
      assign r_vld = cell_vld[i+1];
      assign r_gt  = cell_gt[i+1];
    end

    mms_cell #(.W(SB)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .key_ins_i   (x_q),
      .key_del_i   (oldest),
      .left_val_i  (l_val),
      .left_vld_i  (l_vld),
      .left_lt_i   (l_lt),
      .right_val_i (r_val),
      .right_vld_i (r_vld),
      .right_gt_i  (r_gt),
      .val_o       (cell_val[i]),
      .vld_o       (cell_vld[i]),
      .lt_o        (cell_lt[i]),
      .gt_o        (cell_gt[i])
    );
  end

  mms_div #(.QW(SB), .DW(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (fill_q),
    .quo_o   (mean)
  );

  assign med_sum  = (SB+1)'(lo_q) + (SB+1)'(hi_q);
  assign tgt_sum  = (SB+1)'(mean) + (SB+1)'(med_sum[SB:1]);
  assign target_d = tgt_sum[SB:1];

  // Slew limit: jump from the center code, otherwise fixed steps outside the dead band.
  always_comb begin
    logic [FW-1:0] tg, ce, th, up, dn;
    tg     = FW'(target_q);
    ce     = FW'(center_q);
    th     = FW'(step_q);
    up     = tg - filtered_q;
    dn     = filtered_q - tg;
    filt_d = filtered_q;
    if (filtered_q == ce) begin
      filt_d = tg;
    end else if (tg > filtered_q) begin
      if (up > th) begin
        filt_d = filtered_q + th;
      end
    end else if (dn > th) begin
      filt_d = filtered_q - th;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      sum_q       <= '0;
      k_q         <= '0;
      filtered_q  <= FW'(CENTER_RESET);
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= enable_q ? S_DEL : S_DONE;
          end
        end
        S_DEL: begin
          if (full) begin
            sum_q <= sum_q - SW'(oldest) + SW'(x_q);
          end else begin
            sum_q  <= sum_q + SW'(x_q);
            fill_q <= fill_q + 1'b1;
          end
          state_q <= S_INS;
        end
        S_INS: begin
          k_q     <= '0;
          state_q <= S_RUN;
        end
        S_RUN: begin
          k_q <= k_q + 1'b1;
          if (k_q == KW'(RUN_LEN - 1)) begin
            state_q <= S_TGT;
          end
        end
        S_TGT: begin
          state_q <= S_SLEW;
        end
        S_SLEW: begin
          filtered_q <= filt_d;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q   <= raw;
      res_q <= DATA_W'(raw);
    end
    if (state_q == S_DEL) begin
      line_q[0] <= x_q;
      for (int unsigned i = 1; i < WD; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
    // The head of the rotating row shows the k-th smallest sample.
    if (state_q == S_RUN && k_q == KW'(lo_idx)) begin
      lo_q <= cell_val[0];
    end
    if (state_q == S_RUN && k_q == KW'(hi_idx)) begin
      hi_q <= cell_val[0];
    end
    if (state_q == S_TGT) begin
      target_q <= target_d;
    end
    if (state_q == S_SLEW) begin
      res_q <= DATA_W'(filt_d);
    end
    if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
      out_val_q <= res_q;
    end
  end

endmodule

@@ sv/mms_cell.sv @@
// One cell of the sorted sample row: holds a value and a valid bit.
// Depends on mms_pkg for the row control struct.
module mms_cell import mms_pkg::*; #(
  parameter int unsigned W = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mms_cell_ctl_t ctl_i,
  input  logic [W-1:0]  key_ins_i,
  input  logic [W-1:0]  key_del_i,
  input  logic [W-1:0]  left_val_i,
  input  logic          left_vld_i,
  input  logic          left_lt_i,
  input  logic [W-1:0]  right_val_i,
  input  logic          right_vld_i,
  input  logic          right_gt_i,
  output logic [W-1:0]  val_o,
  output logic          vld_o,
  output logic          lt_o,
  output logic          gt_o
);

  logic [W-1:0] val_q, val_d;
  logic         vld_q, vld_d;
  logic         ge;

  // An empty cell acts as plus infinity, so the filled cells stay at the low end.
  assign lt_o = !vld_q || (key_ins_i < val_q);
  assign gt_o = !vld_q || (val_q > key_del_i);
  assign ge   = !vld_q || (val_q >= key_del_i);

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctl_i.rot) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end else if (ctl_i.del && ge && right_gt_i) begin
      // The last copy of the removed value and everything above it move down.
      val_d = right_val_i;
      vld_d = right_vld_i;
    end else if (ctl_i.ins && lt_o) begin
      if (left_lt_i) begin
        val_d = left_val_i;
        vld_d = left_vld_i;
      end else begin
        val_d = key_ins_i;
        vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule

@@ sv/mms_div.sv @@
// Restoring divider, one quotient bit per cycle, for the window mean.
// Has no dependencies; it uses no package items.
module mms_div #(
  parameter int unsigned QW = 12,
  parameter int unsigned DW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QW+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic [QW-1:0]    quo_o
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q;
  logic [QW-1:0]    quo_q;
  logic [DW-1:0]    den_q;
  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem_q, quo_q[QW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(QW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // The upper part of the dividend is already below the divisor, so only the
  // low QW bits need a step each.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[QW+DW-1:QW];
      quo_q <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign quo_o = quo_q;

endmodule

@@ sv/mms_chk.sv @@
// Port-level checks of the mean/median slew filter, bound to the top level.
// Depends on mms_pkg for the register indexes.
module mms_chk import mms_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic [DATA_W-1:0]    in_sample_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [DATA_W-1:0]    out_value_i,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [DATA_W-1:0]    cfg_data_i
);

  logic       en_q;
  logic [1:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b1;
      pend_q <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_ENABLE) begin
        en_q <= cfg_data_i[0];
      end
      pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("result changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("second sample taken while one is in work");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i |-> pend_q != 2'd0) and (pend_q <= 2'd2))
    else $error("result without a pending sample");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !en_q && !out_valid_i |-> ##2
      (out_valid_i && out_value_i == DATA_W'(SAMPLE_BITS'($past(in_sample_i, 2)))))
    else $error("bypass result does not match the sample");

endmodule

bind mean_median_slew_filter mms_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_mms_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_sample_i (in_i.sample),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i)
);

@@ tb/tb_mean_median_slew_filter.sv @@
// Self-checking testbench for mean_median_slew_filter: directed table, then random phases.
// Depends on mms_pkg and the channel interfaces in mms_if; predicts each value itself unless a table row gives it.
module tb_mean_median_slew_filter import mms_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_DEPTH     = 8;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DIR_ROWS      = 30;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    mms_cfg_e          idx;
    logic [DATA_W-1:0] data;
    logic              has_exp;
    logic [DATA_W-1:0] exp_val;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0] cfg_data_i;

  mms_sample_if smp_if ();
  mms_value_if  val_if ();

  mean_median_slew_filter #(
    .WINDOW_DEPTH(WIN_DEPTH),
    .SAMPLE_BITS (DATA_W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (smp_if),
    .out_o     (val_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Predictor state and its copy of the registers.
  logic              cfg_enable;
  logic [DATA_W-1:0] cfg_center;
  logic [DATA_W-1:0] cfg_step;
  logic [DATA_W-1:0] filt_win [WIN_DEPTH];
  int unsigned       filt_fill;
  int unsigned       filt_wr;
  logic [14:0]       filt_sum;
  logic [DATA_W-1:0] filt_val;

  logic [DATA_W-1:0] value_q [$];
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  int unsigned       src_idle_pct;
  int unsigned       snk_idle_pct;
  int                sig_level = 2048;

  stim_row_t dir_tab [DIR_ROWS] = '{
    // Samples into the window that reset leaves empty.
    '{ROW_SAMPLE, CFG_ENABLE, 12'd2048, 1'b1, 12'd2048},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd0,    1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd4095, 1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd4095, 1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd0,    1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd1,    1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd4094, 1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd2048, 1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd4095, 1'b0, 12'd0},
    // Pass-through: the raw sample comes back unchanged.
    '{ROW_CFG,    CFG_ENABLE, 12'd0,    1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd0,    1'b1, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd4095, 1'b1, 12'd4095},
    '{ROW_SAMPLE, CFG_ENABLE, 12'hAAA,  1'b1, 12'hAAA},
    '{ROW_SAMPLE, CFG_ENABLE, 12'h555,  1'b1, 12'h555},
    '{ROW_CFG,    CFG_ENABLE, 12'd1,    1'b0, 12'd0},
    '{ROW_CFG,    CFG_STEP,   12'd0,    1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd0,    1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd4095, 1'b0, 12'd0},
    '{ROW_CFG,    CFG_STEP,   12'd4095, 1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd0,    1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd4095, 1'b0, 12'd0},
    '{ROW_CFG,    CFG_CENTER, 12'd4095, 1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd4095, 1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd4095, 1'b0, 12'd0},
    '{ROW_CFG,    CFG_CENTER, 12'd0,    1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd0,    1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd0,    1'b0, 12'd0},
    '{ROW_CFG,    CFG_STEP,   12'd8,    1'b0, 12'd0},
    '{ROW_CFG,    CFG_CENTER, 12'd2048, 1'b0, 12'd0},
    '{ROW_SAMPLE, CFG_ENABLE, 12'd2048, 1'b0, 12'd0}
  };

  function automatic void reset_filter_model();
    int unsigned i;
    cfg_enable = 1'b1;
    cfg_center = CENTER_RESET;
    cfg_step   = STEP_RESET;
    for (i = 0; i < WIN_DEPTH; i++) filt_win[i] = CENTER_RESET;
    filt_fill = 0;
    filt_wr   = 0;
    filt_sum  = 15'(CENTER_RESET * WIN_DEPTH);
    filt_val  = CENTER_RESET;
  endfunction

  // With the filter on, advances the window and the slew-limited value by one sample; off, returns it raw.
  function automatic logic [DATA_W-1:0] next_filtered(input logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] srt [WIN_DEPTH];
    logic [DATA_W-1:0] v;
    int unsigned n, i, acc, mean_v, med_v, lo, hi, tgt;
    int j;
    if (!cfg_enable) return raw;
    filt_sum = filt_sum - 15'(filt_win[filt_wr]) + 15'(raw);
    filt_win[filt_wr] = raw;
    filt_wr = (filt_wr + 1) % WIN_DEPTH;
    if (filt_fill < WIN_DEPTH) filt_fill++;
    n = filt_fill;
    acc = 0;
    if (n >= WIN_DEPTH) begin
      acc = filt_sum;
    end else begin
      for (i = 0; i < n; i++) acc += filt_win[i];
    end
    mean_v = acc / n;
    for (i = 0; i < n; i++) begin
      v = filt_win[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    if (n % 2 == 0) begin
      lo = srt[n/2-1];
      hi = srt[n/2];
      med_v = (lo + hi) / 2;
    end else begin
      med_v = srt[n/2];
    end
    tgt = (mean_v + med_v) / 2;
    if (filt_val == cfg_center) begin
      filt_val = tgt[DATA_W-1:0];
    end else if (tgt > filt_val) begin
      if (tgt - filt_val > cfg_step) filt_val = filt_val + cfg_step;
    end else if (filt_val - tgt > cfg_step) begin
      filt_val = filt_val - cfg_step;
    end
    return filt_val;
  endfunction

  // Mostly a level with a little noise that jumps now and then, as a joystick axis gives,
  // mixed with full-range values, rail codes and single-bit spikes.
  function automatic logic [DATA_W-1:0] pick_sample();
    int unsigned r;
    int v;
    r = $urandom_range(99);
    if (r < 8) sig_level = $urandom_range(4095);
    if (r < 65) begin
      v = sig_level + int'($urandom_range(40)) - 20;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
    end else if (r < 85) begin
      v = $urandom_range(4095);
    end else if (r < 93) begin
      v = (r % 2 == 1) ? 4095 : 0;
    end else begin
      v = sig_level ^ (1 << $urandom_range(DATA_W - 1));
    end
    return v[DATA_W-1:0];
  endfunction

  task automatic write_reg(input mms_cfg_e idx, input logic [DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLE: cfg_enable = data[0];
      CFG_CENTER: cfg_center = data;
      CFG_STEP:   cfg_step   = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Returns at the edge where the sample transfer takes place; valid stays high.
  task automatic send_sample(input logic [DATA_W-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  task automatic settle();
    smp_if.valid <= 1'b0;
    while (value_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: value expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    logic [DATA_W-1:0] want;
    if (rst_ni && val_if.valid && val_if.ready) begin
      if (value_q.size() == 0) begin
        note_mismatch("result transfer with nothing outstanding", 'x, val_if.value);
      end else begin
        want = value_q.pop_front();
        if (val_if.value !== want) note_mismatch("value mismatch", want, val_if.value);
      end
    end
    val_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_mean_median_slew_filter: errors");
      $finish;
    end
  end

  initial begin
    int unsigned k, p, n_items;
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] pred;
    logic [DATA_W-1:0] step_pick;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ENABLE;
    cfg_data_i    = '0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    val_if.ready  = 1'b0;
    src_idle_pct  = 15;
    snk_idle_pct  = 81;
    reset_filter_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DIR_ROWS; k++) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[k].idx, dir_tab[k].data);
      end else begin
        send_sample(dir_tab[k].data);
        pred = next_filtered(dir_tab[k].data);
        value_q.push_back(dir_tab[k].has_exp ? dir_tab[k].exp_val : pred);
      end
    end

    // Four settings under each idling regime; two phases run with the filter off.
    for (p = 0; p < 12; p++) begin
      case (p / 4)
        0: begin src_idle_pct = 15; snk_idle_pct = 81; end
        1: begin src_idle_pct = 81; snk_idle_pct = 15; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      settle();
      case (p % 4)
        0: begin
          write_reg(CFG_STEP, 12'($urandom_range(1, 12)));
          write_reg(CFG_CENTER, filt_val);
        end
        1: begin
          case ($urandom_range(2))
            0: step_pick = '0;
            1: step_pick = '1;
            default: step_pick = 12'($urandom_range(4095));
          endcase
          write_reg(CFG_STEP, step_pick);
          write_reg(CFG_CENTER, 12'($urandom_range(4095)));
        end
        2: begin
          write_reg(CFG_STEP, 12'($urandom_range(64)));
          write_reg(CFG_CENTER, filt_val);
        end
        default: begin
          write_reg(CFG_STEP, 12'd1);
          write_reg(CFG_CENTER, (p % 8 == 3) ? 12'd0 : 12'd4095);
        end
      endcase
      write_reg(CFG_ENABLE, (p % 6 == 5) ? 12'd0 : 12'd1);
      n_items = (p % 6 == 5) ? 40 : 175;
      repeat (n_items) begin
        s = pick_sample();
        send_sample(s);
        value_q.push_back(next_filtered(s));
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_mean_median_slew_filter: clean");
    end else begin
      $display("tb_mean_median_slew_filter: errors");
    end
    $finish;
  end

endmodule

@@ mean_median_slew_filter.f @@
sv/mms_pkg.sv
sv/mms_if.sv
sv/mms_cell.sv
sv/mms_div.sv
sv/mean_median_slew_filter.sv
sv/mms_chk.sv
tb/tb_mean_median_slew_filter.sv
